### design/median_filtered_pi_regulator_assert.svh
// Assertion macros for the median-filtered PI regulator.
`ifndef MEDIAN_FILTERED_PI_REGULATOR_ASSERT_SVH
`define MEDIAN_FILTERED_PI_REGULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define MFPR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define MFPR_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");
`else
`define MFPR_ASSERT(lbl, clk, rstn, prop)
`define MFPR_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

### design/mfpr_pkg.sv
// Shared types and constants of the median-filtered PI regulator.
package mfpr_pkg;

    localparam int DATA_W = 16;
    localparam int ERR_W  = 17;
    localparam int DIFF_W = 18;
    localparam int FRAC_W = 12;

    localparam logic [DATA_W-1:0] SETPOINT_RST   = 16'd1049;
    localparam logic [DATA_W-1:0] PROP_GAIN_RST  = 16'd4915;
    localparam logic [DATA_W-1:0] INTEG_GAIN_RST = 16'd123;
    localparam logic [DATA_W-1:0] LEVEL_HIGH_RST = 16'd45875;
    localparam logic [DATA_W-1:0] LEVEL_LOW_RST  = 16'd17039;
    localparam logic [DATA_W-1:0] LEVEL_RST      = 16'd11796;

    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_SETPOINT   = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [2:0] REG_LEVEL_HIGH = 3'd3;
    localparam logic [2:0] REG_LEVEL_LOW  = 3'd4;

    // median of a completed window, handed from sorter to regulator
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] value;
    } median_req_t;

endpackage

### design/median_filtered_pi_regulator.sv
// Top level of the median-filtered PI regulator: register port, sorter and PI pipeline.
// Accepts one sample per cycle unless stalled; the sorter chain inserts it in the cycle it arrives.
// A result passes the sorter's median register, PI stages A, B, C and the output register.
// A window-completing sample is stalled while the previous result is in flight or untaken.
// Reset (rst_n, async low) clears the fill count, previous error and pipeline valids,
// loads the register defaults and sets the drive level to 11796.
module median_filtered_pi_regulator
#(
    parameter int WINDOW = 15
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mfpr_pkg::DATA_W-1:0]   sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mfpr_pkg::DATA_W-1:0]   median_value,
    output logic [mfpr_pkg::DATA_W-1:0]   drive_level,
    output logic [mfpr_pkg::DATA_W-2:0]   dac_amplitude,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mfpr_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [mfpr_pkg::DATA_W-1:0] setpoint_reg;
    logic [mfpr_pkg::DATA_W-1:0] prop_gain_reg;
    logic [mfpr_pkg::DATA_W-1:0] integ_gain_reg;
    logic [mfpr_pkg::DATA_W-1:0] level_high_reg;
    logic [mfpr_pkg::DATA_W-1:0] level_low_reg;
    logic                        wr_en;
    logic [mfpr_pkg::DATA_W-1:0] rd_val;

    logic                        ins;
    logic                        complete;
    logic                        busy;
    mfpr_pkg::median_req_t       med;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg   <= mfpr_pkg::SETPOINT_RST;
            prop_gain_reg  <= mfpr_pkg::PROP_GAIN_RST;
            integ_gain_reg <= mfpr_pkg::INTEG_GAIN_RST;
            level_high_reg <= mfpr_pkg::LEVEL_HIGH_RST;
            level_low_reg  <= mfpr_pkg::LEVEL_LOW_RST;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                mfpr_pkg::REG_SETPOINT:   setpoint_reg   <= pwdata[15:0];
                mfpr_pkg::REG_PROP_GAIN:  prop_gain_reg  <= pwdata[15:0];
                mfpr_pkg::REG_INTEG_GAIN: integ_gain_reg <= pwdata[15:0];
                mfpr_pkg::REG_LEVEL_HIGH: level_high_reg <= pwdata[15:0];
                mfpr_pkg::REG_LEVEL_LOW:  level_low_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            mfpr_pkg::REG_SETPOINT:   rd_val = setpoint_reg;
            mfpr_pkg::REG_PROP_GAIN:  rd_val = prop_gain_reg;
            mfpr_pkg::REG_INTEG_GAIN: rd_val = integ_gain_reg;
            mfpr_pkg::REG_LEVEL_HIGH: rd_val = level_high_reg;
            mfpr_pkg::REG_LEVEL_LOW:  rd_val = level_low_reg;
            default:                  rd_val = '0;
        endcase
    end

    assign prdata = {16'd0, rd_val};

    // hold off the window-closing request until the pipeline is empty
    assign in_stall = complete & busy;
    assign ins      = in_valid & ~in_stall;

    mfpr_sorter
    #(
        .WINDOW (WINDOW)
    )
    u_sorter
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ins      (ins),
        .x        (sample),
        .complete (complete),
        .med      (med)
    );

    mfpr_pi u_pi
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .med           (med),
        .setpoint      (setpoint_reg),
        .prop_gain     (prop_gain_reg),
        .integ_gain    (integ_gain_reg),
        .level_high    (level_high_reg),
        .level_low     (level_low_reg),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .median_value  (median_value),
        .drive_level   (drive_level),
        .dac_amplitude (dac_amplitude),
        .busy          (busy)
    );

endmodule

### design/mfpr_sort_cell.sv
// One cell of the insertion sort chain: holds one window sample in sorted position.
module mfpr_sort_cell
(
    input  logic                        clk,
    input  logic                        ins,
    input  logic [mfpr_pkg::DATA_W-1:0] x,
    input  logic                        occupied,
    input  logic [mfpr_pkg::DATA_W-1:0] left_val,
    input  logic                        left_gt,
    output logic [mfpr_pkg::DATA_W-1:0] val,
    output logic                        gt,
    output logic [mfpr_pkg::DATA_W-1:0] val_next
);

    logic [mfpr_pkg::DATA_W-1:0] val_reg;

    // empty cells act as +infinity
    assign gt  = !occupied || (val_reg > x);
    assign val = val_reg;

    always_comb
    begin
        if (left_gt)
        begin
            val_next = left_val;
        end
        else if (gt)
        begin
            val_next = x;
        end
        else
        begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins)
        begin
            val_reg <= val_next;
        end
    end

endmodule

### design/mfpr_sorter.sv
// Window fill counter and chain of sort cells; emits the median of each full window.
module mfpr_sorter
#(
    parameter int WINDOW = 15
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ins,
    input  logic [mfpr_pkg::DATA_W-1:0] x,
    output logic                        complete,
    output mfpr_pkg::median_req_t       med
);

    localparam int CNT_W = $clog2(WINDOW);
    localparam int MID   = WINDOW / 2;

    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic [mfpr_pkg::DATA_W-1:0] cell_val  [WINDOW];
    logic [mfpr_pkg::DATA_W-1:0] cell_next [WINDOW];
    logic                        cell_gt   [WINDOW];
    logic                        med_valid_reg;
    logic [mfpr_pkg::DATA_W-1:0] med_value_reg;
    mfpr_pkg::median_req_t       med_next;

    assign complete = (cnt_reg == CNT_W'(WINDOW - 1));

    genvar i;
    generate
        for (i = 0; i < WINDOW; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                mfpr_sort_cell u_cell
                (
                    .clk      (clk),
                    .ins      (ins),
                    .x        (x),
                    .occupied (cnt_reg > CNT_W'(i)),
                    .left_val (x),
                    .left_gt  (1'b0),
                    .val      (cell_val[i]),
                    .gt       (cell_gt[i]),
                    .val_next (cell_next[i])
                );
            end
            else
            begin : g_body
                mfpr_sort_cell u_cell
                (
                    .clk      (clk),
                    .ins      (ins),
                    .x        (x),
                    .occupied (cnt_reg > CNT_W'(i)),
                    .left_val (cell_val[i-1]),
                    .left_gt  (cell_gt[i-1]),
                    .val      (cell_val[i]),
                    .gt       (cell_gt[i]),
                    .val_next (cell_next[i])
                );
            end
        end
    endgenerate

    always_comb
    begin
        cnt_next       = cnt_reg;
        med_next.valid = 1'b0;
        med_next.value = cell_next[MID];
        if (ins)
        begin
            if (complete)
            begin
                cnt_next       = '0;
                med_next.valid = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            med_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            med_valid_reg <= med_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (med_next.valid)
        begin
            med_value_reg <= med_next.value;
        end
    end

    assign med = mfpr_pkg::median_req_t'({med_valid_reg, med_value_reg});

endmodule

### design/mfpr_pi.sv
// Incremental PI step pipeline: error, gain products, rounding/saturation, level clamp.
`include "median_filtered_pi_regulator_assert.svh"
module mfpr_pi
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mfpr_pkg::median_req_t       med,
    input  logic [mfpr_pkg::DATA_W-1:0] setpoint,
    input  logic [mfpr_pkg::DATA_W-1:0] prop_gain,
    input  logic [mfpr_pkg::DATA_W-1:0] integ_gain,
    input  logic [mfpr_pkg::DATA_W-1:0] level_high,
    input  logic [mfpr_pkg::DATA_W-1:0] level_low,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic [mfpr_pkg::DATA_W-1:0] median_value,
    output logic [mfpr_pkg::DATA_W-1:0] drive_level,
    output logic [mfpr_pkg::DATA_W-2:0] dac_amplitude,
    output logic                        busy
);

    localparam int PP_W  = mfpr_pkg::DIFF_W + mfpr_pkg::DATA_W + 1;
    localparam int PI_W  = mfpr_pkg::ERR_W + mfpr_pkg::DATA_W + 1;
    localparam int SUM_W = PP_W + 1;
    localparam int LVL_W = mfpr_pkg::DATA_W + 3;

    // stage A: error and error difference
    logic                               va_reg;
    logic signed [mfpr_pkg::ERR_W-1:0]  err_a_reg;
    logic signed [mfpr_pkg::DIFF_W-1:0] diff_a_reg;
    logic [mfpr_pkg::DATA_W-1:0]        med_a_reg;
    logic signed [mfpr_pkg::ERR_W-1:0]  prev_err_reg;
    logic signed [mfpr_pkg::ERR_W-1:0]  err_next;
    logic signed [mfpr_pkg::DIFF_W-1:0] diff_next;

    // stage B: gain products
    logic                               vb_reg;
    logic signed [PP_W-1:0]             prod_p_reg;
    logic signed [PI_W-1:0]             prod_i_reg;
    logic signed [PP_W-1:0]             prod_p_next;
    logic signed [PI_W-1:0]             prod_i_next;

    // stage C: rounded, saturated step
    logic                               vc_reg;
    logic signed [mfpr_pkg::ERR_W-1:0]  step_c_reg;
    logic signed [mfpr_pkg::ERR_W-1:0]  step_next;
    logic signed [SUM_W-1:0]            sum;
    logic signed [SUM_W-1:0]            shifted;

    // stage D: level update and output register
    logic                               out_valid_reg;
    logic [mfpr_pkg::DATA_W-1:0]        level_reg;
    logic [mfpr_pkg::DATA_W-1:0]        level_next;
    logic signed [LVL_W-1:0]            lvl;

    assign err_next  = $signed({1'b0, setpoint}) - $signed({1'b0, med.value});
    assign diff_next = $signed({err_next[mfpr_pkg::ERR_W-1], err_next})
                     - $signed({prev_err_reg[mfpr_pkg::ERR_W-1], prev_err_reg});

    assign prod_p_next = $signed({1'b0, prop_gain}) * diff_a_reg;
    assign prod_i_next = $signed({1'b0, integ_gain}) * err_a_reg;

    assign sum = $signed({prod_p_reg[PP_W-1], prod_p_reg})
               + $signed({{(SUM_W-PI_W){prod_i_reg[PI_W-1]}}, prod_i_reg});
    // floor shift gives round-to-nearest, ties toward +inf
    assign shifted = (sum + SUM_W'(signed'(1 <<< (mfpr_pkg::FRAC_W - 1))))
                     >>> mfpr_pkg::FRAC_W;

    always_comb
    begin
        if (shifted > SUM_W'(signed'(65535)))
        begin
            step_next = mfpr_pkg::ERR_W'(signed'(65535));
        end
        else if (shifted < SUM_W'(signed'(-65535)))
        begin
            step_next = mfpr_pkg::ERR_W'(signed'(-65535));
        end
        else
        begin
            step_next = shifted[mfpr_pkg::ERR_W-1:0];
        end
    end

    assign lvl = $signed({3'b000, level_reg})
               - $signed({{2{step_c_reg[mfpr_pkg::ERR_W-1]}}, step_c_reg});

    always_comb
    begin
        if (lvl > $signed({3'b000, level_high}))
        begin
            level_next = level_high;
        end
        else if (lvl < $signed({3'b000, level_low}))
        begin
            level_next = level_low;
        end
        else
        begin
            level_next = lvl[mfpr_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_err_reg  <= '0;
            level_reg     <= mfpr_pkg::LEVEL_RST;
        end
        else
        begin
            va_reg <= med.valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            if (med.valid)
            begin
                prev_err_reg <= err_next;
            end
            if (vc_reg)
            begin
                level_reg     <= level_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (med.valid)
        begin
            err_a_reg  <= err_next;
            diff_a_reg <= diff_next;
            med_a_reg  <= med.value;
        end
        if (va_reg)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
        end
        if (vb_reg)
        begin
            step_c_reg <= step_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign median_value  = med_a_reg;
    assign drive_level   = level_reg;
    assign dac_amplitude = level_reg[mfpr_pkg::DATA_W-1:1];
    assign busy          = med.valid | va_reg | vb_reg | vc_reg | out_valid_reg;

    // only one window result may be in flight at a time
    `MFPR_ASSERT(a_one_in_flight, clk, rst_n,
        $onehot0({med.valid, va_reg, vb_reg, vc_reg, out_valid_reg}))
    `MFPR_ASSERT(a_step_reaches_out, clk, rst_n, vc_reg |=> out_valid_reg)
    `MFPR_ASSERT_NEVER(a_level_outside_clamp, clk, rst_n,
        out_valid_reg && (level_low <= level_high)
        && ((level_reg > level_high) || (level_reg < level_low)))

endmodule

### tb/regulator_checker.sv
// Checker for the median-filtered PI regulator: tracks register writes, predicts results, compares.
module regulator_checker
#(
    parameter int WINDOW = 15
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [mfpr_pkg::DATA_W-1:0]   sample,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [mfpr_pkg::DATA_W-1:0]   median_value,
    input  logic [mfpr_pkg::DATA_W-1:0]   drive_level,
    input  logic [mfpr_pkg::DATA_W-2:0]   dac_amplitude,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [mfpr_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output int                            fail_count,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [mfpr_pkg::DATA_W-1:0] median;
        logic [mfpr_pkg::DATA_W-1:0] level;
        logic [mfpr_pkg::DATA_W-2:0] amplitude;
    } regulation_t;

    regulation_t expected_q[$];

    logic [mfpr_pkg::DATA_W-1:0] setpoint_r;
    logic [mfpr_pkg::DATA_W-1:0] prop_gain_r;
    logic [mfpr_pkg::DATA_W-1:0] integ_gain_r;
    logic [mfpr_pkg::DATA_W-1:0] level_high_r;
    logic [mfpr_pkg::DATA_W-1:0] level_low_r;

    logic [mfpr_pkg::DATA_W-1:0] window_r [WINDOW];
    int                          fill_r;
    int                          prev_err_r;
    logic [mfpr_pkg::DATA_W-1:0] level_r;

    task automatic report(input string what, input int got, input int want);
        $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [mfpr_pkg::DATA_W-1:0] got,
                               input logic [mfpr_pkg::DATA_W-1:0] want);
        if (got !== want)
            report(what, int'(got), int'(want));
    endtask

    function automatic logic [mfpr_pkg::DATA_W-1:0] window_median();
        logic [mfpr_pkg::DATA_W-1:0] sorted [WINDOW];
        logic [mfpr_pkg::DATA_W-1:0] v;
        int j;
        sorted = window_r;
        for (int i = 1; i < WINDOW; i++)
        begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > v)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[WINDOW/2];
    endfunction

    // Incremental PI step on the median of a full window.
    task automatic close_window();
        logic [mfpr_pkg::DATA_W-1:0] med;
        int                          err;
        longint                      acc;
        regulation_t                 res;
        med = window_median();
        err = int'(setpoint_r) - int'(med);
        acc = longint'(prop_gain_r) * longint'(err - prev_err_r)
            + longint'(integ_gain_r) * longint'(err);
        // round to nearest code, ties up
        acc = (acc + 2048) >>> mfpr_pkg::FRAC_W;
        if (acc > 65535)
            acc = 65535;
        else if (acc < -65535)
            acc = -65535;
        acc = longint'(level_r) - acc;
        // upper clamp wins when the limits cross
        if (acc > longint'(level_high_r))
            acc = longint'(level_high_r);
        else if (acc < longint'(level_low_r))
            acc = longint'(level_low_r);
        level_r    = acc[mfpr_pkg::DATA_W-1:0];
        prev_err_r = err;
        res.median    = med;
        res.level     = level_r;
        res.amplitude = level_r[mfpr_pkg::DATA_W-1:1];
        expected_q.push_back(res);
    endtask

    task automatic take_result();
        regulation_t want;
        if (expected_q.size() == 0)
        begin
            report("result with no request pending, drive_level", int'(drive_level), -1);
        end
        else
        begin
            want = expected_q.pop_front();
            check_field("median_value", median_value, want.median);
            check_field("drive_level", drive_level, want.level);
            check_field("dac_amplitude", {1'b0, dac_amplitude}, {1'b0, want.amplitude});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_r   = mfpr_pkg::SETPOINT_RST;
            prop_gain_r  = mfpr_pkg::PROP_GAIN_RST;
            integ_gain_r = mfpr_pkg::INTEG_GAIN_RST;
            level_high_r = mfpr_pkg::LEVEL_HIGH_RST;
            level_low_r  = mfpr_pkg::LEVEL_LOW_RST;
            fill_r       = 0;
            prev_err_r   = 0;
            level_r      = mfpr_pkg::LEVEL_RST;
            expected_q.delete();
            pending      = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[mfpr_pkg::ADDR_W-1:2])
                    mfpr_pkg::REG_SETPOINT:   setpoint_r   = pwdata[mfpr_pkg::DATA_W-1:0];
                    mfpr_pkg::REG_PROP_GAIN:  prop_gain_r  = pwdata[mfpr_pkg::DATA_W-1:0];
                    mfpr_pkg::REG_INTEG_GAIN: integ_gain_r = pwdata[mfpr_pkg::DATA_W-1:0];
                    mfpr_pkg::REG_LEVEL_HIGH: level_high_r = pwdata[mfpr_pkg::DATA_W-1:0];
                    mfpr_pkg::REG_LEVEL_LOW:  level_low_r  = pwdata[mfpr_pkg::DATA_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                window_r[fill_r] = sample;
                fill_r++;
                if (fill_r == WINDOW)
                begin
                    fill_r = 0;
                    close_window();
                end
            end
            if (out_valid && !out_stall)
                take_result();
            pending = expected_q.size();
        end
    end

endmodule

### tb/tb.sv
// Testbench top for the median-filtered PI regulator: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW = 15;
    localparam int ITEMS_PER_PHASE = 43;
    localparam int LONG_HOLD = 300;
    // indexes with no register behind them
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic [mfpr_pkg::DATA_W-1:0]   sample    = '0;
    logic                          out_stall = 1'b0;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [mfpr_pkg::ADDR_W-1:0]   paddr     = '0;
    logic [31:0]                   pwdata    = '0;
    logic                          in_stall;
    logic                          out_valid;
    logic [mfpr_pkg::DATA_W-1:0]   median_value;
    logic [mfpr_pkg::DATA_W-1:0]   drive_level;
    logic [mfpr_pkg::DATA_W-2:0]   dac_amplitude;
    logic [31:0]                   prdata;
    logic                          pready;

    int                            fail_count;
    int                            pending;
    bit                            quiet;
    bit                            long_hold_req;
    logic [mfpr_pkg::DATA_W-1:0]   center;

    median_filtered_pi_regulator #(.WINDOW(WINDOW)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .median_value(median_value), .drive_level(drive_level),
        .dac_amplitude(dac_amplitude),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    regulator_checker #(.WINDOW(WINDOW)) regulation_check (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .median_value(median_value), .drive_level(drive_level),
        .dac_amplitude(dac_amplitude),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic write_reg(input logic [2:0] index,
                             input logic [mfpr_pkg::DATA_W-1:0] value);
        logic [15:0] upper;
        upper = 16'($urandom());
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {upper, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [mfpr_pkg::DATA_W-1:0] sp,
                             input logic [mfpr_pkg::DATA_W-1:0] kp,
                             input logic [mfpr_pkg::DATA_W-1:0] ki,
                             input logic [mfpr_pkg::DATA_W-1:0] hi,
                             input logic [mfpr_pkg::DATA_W-1:0] lo);
        write_reg(mfpr_pkg::REG_SETPOINT, sp);
        write_reg(mfpr_pkg::REG_PROP_GAIN, kp);
        write_reg(mfpr_pkg::REG_INTEG_GAIN, ki);
        write_reg(mfpr_pkg::REG_LEVEL_HIGH, hi);
        write_reg(mfpr_pkg::REG_LEVEL_LOW, lo);
        center = sp;
    endtask

    // valid stays high across back-to-back requests
    task automatic push_sample(input logic [mfpr_pkg::DATA_W-1:0] value);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do @(posedge clk); while (in_stall);
    endtask

    // wait out every pending result plus the pipeline depth
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [mfpr_pkg::DATA_W-1:0] draw_sample(
        input logic [mfpr_pkg::DATA_W-1:0] mid);
        int v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 65535);
            1: v = $urandom_range(0, 1) ? 65535 : 0;
            2: v = 1 << $urandom_range(0, 15);
            3: v = 65535 ^ (1 << $urandom_range(0, 15));
            default: v = int'(mid) + int'($urandom_range(0, 4000)) - 2000;
        endcase
        if (v < 0)
            v = 0;
        else if (v > 65535)
            v = 65535;
        return v[mfpr_pkg::DATA_W-1:0];
    endfunction

    // result side
    initial
    begin
        int hold;
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            hold = quiet ? 0 : $urandom_range(0, 17);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // median at full scale against setpoint zero: step saturates negative, upper clamp
        configure(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        for (int i = 0; i < WINDOW; i++)
            push_sample((i % 2 == 0) ? 16'hFFFF : 16'h0000);
        drain();
        // median zero against full-scale setpoint: positive saturation, lower clamp
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd40000, 16'd20000);
        write_reg(REG_SPARE_LO, 16'h5A5A);
        write_reg(REG_SPARE_HI, 16'hA5A5);
        for (int i = 0; i < WINDOW; i++)
            push_sample(16'h0000);

        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            case (phase)
                0: configure(mfpr_pkg::SETPOINT_RST, mfpr_pkg::PROP_GAIN_RST,
                             mfpr_pkg::INTEG_GAIN_RST, mfpr_pkg::LEVEL_HIGH_RST,
                             mfpr_pkg::LEVEL_LOW_RST);
                1: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                // crossed limits
                3: configure(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 8191)),
                             16'($urandom_range(0, 1023)), 16'($urandom_range(0, 32767)),
                             16'($urandom_range(32768, 65535)));
                4: configure(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 16383)),
                             16'($urandom_range(0, 16383)), 16'hFFFF, 16'h0000);
                default: configure(16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)));
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                push_sample(draw_sample(center));
        end

        // result side holds off while requests keep coming, so the input backs up
        drain();
        configure(mfpr_pkg::SETPOINT_RST, mfpr_pkg::PROP_GAIN_RST, mfpr_pkg::INTEG_GAIN_RST,
                  16'hFFFF, 16'h0000);
        quiet = 1'b1;
        long_hold_req = 1'b1;
        for (int i = 0; i < 5 * WINDOW; i++)
            push_sample(draw_sample(center));
        quiet = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
